/* sv/apma_pkg.sv */
// ----------------------------------------------------------------------------
// apma_pkg
// Shared types and constants of the ASCII pair moving average unit.
// ----------------------------------------------------------------------------
`default_nettype none

package apma_pkg;

  // Ring depth and derived widths
  localparam int WINDOW     = 5;
  localparam int PTR_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W      = $clog2(WINDOW + 1);
  localparam int VAL_W      = 16;
  localparam int MEM_W      = 2 * VAL_W;
  localparam int SUM_W      = VAL_W + $clog2(WINDOW);
  localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

  // Characters of interest
  localparam logic [7:0] CHAR_FIRST_KEPT = 8'h20;
  localparam logic [7:0] CHAR_LAST_KEPT  = 8'h7E;
  localparam logic [7:0] CHAR_SPACE      = 8'h20;
  localparam logic [7:0] CHAR_PLUS       = 8'h2B;
  localparam logic [7:0] CHAR_COMMA      = 8'h2C;
  localparam logic [7:0] CHAR_MINUS      = 8'h2D;
  localparam logic [7:0] CHAR_ZERO       = 8'h30;
  localparam logic [7:0] CHAR_NINE       = 8'h39;

  // Position inside one number
  typedef enum logic [1:0] {
    SUB_SKIP  = 2'd0,
    SUB_DIGIT = 2'd1,
    SUB_DONE  = 2'd2
  } sub_e;

  // Sequencer of the top level
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SUM  = 2'd1,
    ST_DIV  = 2'd2,
    ST_PUSH = 2'd3
  } ctrl_e;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

/* sv/apma_div.sv */
// ----------------------------------------------------------------------------
// apma_div
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module apma_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic signed [apma_pkg::SUM_W-1:0] dividend_i,
  input  wire logic [apma_pkg::CNT_W-1:0]     divisor_i,
  output apma_pkg::div_stat_t                 stat_o,
  output logic signed [apma_pkg::VAL_W-1:0]   quotient_o
);
  import apma_pkg::*;

  logic                 busy_q, done_q, neg_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0]     mag_q;
  logic [CNT_W-1:0]     rem_q, div_q;
  logic [CNT_W:0]       trial;
  logic                 take;
  logic [SUM_W-1:0]     quot_full;

  assign trial = {rem_q, mag_q[SUM_W-1]};
  assign take  = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(SUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SUM_W-1];
      mag_q <= dividend_i[SUM_W-1] ? (SUM_W'(0) - dividend_i) : dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract when it fits
      rem_q <= take ? CNT_W'(trial - {1'b0, div_q}) : CNT_W'(trial);
      mag_q <= {mag_q[SUM_W-2:0], take};
    end
  end

  assign quot_full  = neg_q ? (SUM_W'(0) - mag_q) : mag_q;
  assign quotient_o = VAL_W'(quot_full);
  assign stat_o     = '{busy: busy_q, done: done_q};

endmodule

`default_nettype wire

/* sv/ascii_pair_moving_average_unit.sv */
// Flow: a byte without last, or a last byte without a valid pair, is taken while the sequencer idles.
// A last byte that closes a valid pair holds tready low while the pair is averaged: one ring
// read per entry through the single read port, then the bit-serial dividers, then the output
// register is loaded once it is free.
// Reset: sequencer, parse state, write position and fill flag clear; ring contents stay
// undefined and are never read before being written.
// ----------------------------------------------------------------------------
// ascii_pair_moving_average_unit
// Parses "IR,distance" text replies and averages the pairs over a ring window.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_pair_moving_average_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  wire logic        s_axis_tlast,   // last byte of the reply
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata    // [15:0] ir_average, [31:16] distance_average,
                                           // [34:32] samples_used, [39:35] zero
);
  import apma_pkg::*;

  // --------------------------------------------------------------------------
  // Digit accumulate with saturation to 16-bit signed
  // --------------------------------------------------------------------------
  function automatic logic signed [VAL_W-1:0] add_digit(
    input logic signed [VAL_W-1:0] v,
    input logic [3:0]              d,
    input logic                    neg
  );
    logic signed [VAL_W+4:0] w;
    w = (21'(v) <<< 3) + (21'(v) <<< 1);
    if (neg) begin
      w = w - $signed({17'd0, d});
      if (w < -21'sd32768) w = -21'sd32768;
    end else begin
      w = w + $signed({17'd0, d});
      if (w > 21'sd32767) w = 21'sd32767;
    end
    return VAL_W'(w);
  endfunction

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  ctrl_e state_q, state_d;

  logic s_hs, start_sum, sum_done, rd_en, div_start, load_out;

  // parse state
  logic                    in_b_q, in_b_d;
  sub_e                    sub_q, sub_d;
  logic                    neg_q, neg_d;
  logic                    chars_q, chars_d;
  logic signed [VAL_W-1:0] first_q, second_q, first_d, second_d;
  logic signed [VAL_W-1:0] v_cur, v_nx;
  logic                    kept, digit, pair_ok;

  // ring and averaging
  logic [MEM_W-1:0]        mem_q [WINDOW];
  logic [MEM_W-1:0]        rd_data_q;
  logic                    rd_vld_q;
  logic [CNT_W-1:0]        rd_cnt_q;
  logic [PTR_W-1:0]        wp_q;
  logic                    full_q;
  logic [CNT_W-1:0]        n_q;
  logic signed [SUM_W-1:0] acc_ir_q, acc_dist_q;
  logic signed [VAL_W-1:0] rd_ir, rd_dist;

  // dividers and output register
  div_stat_t               ir_stat, dist_stat;
  logic signed [VAL_W-1:0] ir_quot, dist_quot;
  logic                    m_valid_q;
  logic [VAL_W-1:0]        ir_out_q, dist_out_q;
  logic [2:0]              samp_q;

  assign s_hs = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // Parser: next parse state for the byte on the input
  // --------------------------------------------------------------------------
  assign kept  = (s_axis_tdata >= CHAR_FIRST_KEPT) && (s_axis_tdata <= CHAR_LAST_KEPT);
  assign digit = (s_axis_tdata >= CHAR_ZERO) && (s_axis_tdata <= CHAR_NINE);
  assign v_cur = in_b_q ? second_q : first_q;

  always_comb begin
    in_b_d  = in_b_q;
    sub_d   = sub_q;
    neg_d   = neg_q;
    chars_d = chars_q;
    v_nx    = v_cur;
    if (kept) begin
      if (!in_b_q && (s_axis_tdata == CHAR_COMMA)) begin
        // comma always opens the second number
        in_b_d = 1'b1;
        sub_d  = SUB_SKIP;
        neg_d  = 1'b0;
      end else begin
        if (!in_b_q) chars_d = 1'b1;
        unique case (sub_q)
          SUB_SKIP: begin
            if (s_axis_tdata == CHAR_SPACE) begin
              sub_d = SUB_SKIP;
            end else if (s_axis_tdata == CHAR_PLUS) begin
              neg_d = 1'b0;
              sub_d = SUB_DIGIT;
            end else if (s_axis_tdata == CHAR_MINUS) begin
              neg_d = 1'b1;
              sub_d = SUB_DIGIT;
            end else if (digit) begin
              neg_d = 1'b0;
              v_nx  = add_digit(v_cur, s_axis_tdata[3:0], 1'b0);
              sub_d = SUB_DIGIT;
            end else begin
              sub_d = SUB_DONE;
            end
          end
          SUB_DIGIT: begin
            if (digit) begin
              v_nx = add_digit(v_cur, s_axis_tdata[3:0], neg_q);
            end else begin
              sub_d = SUB_DONE;
            end
          end
          SUB_DONE: sub_d = SUB_DONE;
          default:  sub_d = SUB_DONE;
        endcase
      end
    end
    first_d  = in_b_q ? first_q : v_nx;
    second_d = in_b_q ? v_nx : second_q;
  end

  // a pair counts only once the comma is seen after some text
  assign pair_ok = in_b_d && chars_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_b_q   <= 1'b0;
      sub_q    <= SUB_SKIP;
      neg_q    <= 1'b0;
      chars_q  <= 1'b0;
      first_q  <= '0;
      second_q <= '0;
    end else if (s_hs) begin
      if (s_axis_tlast) begin
        // end of reply: drop the parse state, result or not
        in_b_q   <= 1'b0;
        sub_q    <= SUB_SKIP;
        neg_q    <= 1'b0;
        chars_q  <= 1'b0;
        first_q  <= '0;
        second_q <= '0;
      end else begin
        in_b_q   <= in_b_d;
        sub_q    <= sub_d;
        neg_q    <= neg_d;
        chars_q  <= chars_d;
        first_q  <= first_d;
        second_q <= second_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign sum_done = (rd_cnt_q == n_q) && !rd_vld_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_sum)     state_d = ST_SUM;
      ST_SUM:  if (sum_done)      state_d = ST_DIV;
      ST_DIV:  if (ir_stat.done)  state_d = ST_PUSH;
      ST_PUSH: if (load_out)      state_d = ST_IDLE;
      default:                    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    start_sum     = 1'b0;
    rd_en         = 1'b0;
    div_start     = 1'b0;
    load_out      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        start_sum     = s_axis_tvalid && s_axis_tlast && pair_ok;
      end
      ST_SUM: begin
        rd_en     = (rd_cnt_q != n_q);
        div_start = sum_done;
      end
      ST_DIV:  ;
      ST_PUSH: load_out = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Ring memory: one write port, one registered read port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (start_sum) begin
      mem_q[wp_q] <= {first_d, second_d};
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_cnt_q[PTR_W-1:0]];
    end
  end

  // write position and fill flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      full_q <= 1'b0;
    end else if (start_sum) begin
      if (wp_q == PTR_W'(WINDOW - 1)) begin
        wp_q   <= '0;
        full_q <= 1'b1;
      end else begin
        wp_q <= wp_q + PTR_W'(1);
      end
    end
  end

  // read sweep over the filled entries; the write above lands before the first read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_cnt_q <= '0;
      rd_vld_q <= 1'b0;
      n_q      <= CNT_W'(1);
    end else begin
      rd_vld_q <= rd_en;
      if (start_sum) begin
        rd_cnt_q <= '0;
        n_q      <= full_q ? CNT_W'(WINDOW) : (CNT_W'(wp_q) + CNT_W'(1));
      end else if (rd_en) begin
        rd_cnt_q <= rd_cnt_q + CNT_W'(1);
      end
    end
  end

  assign rd_ir   = rd_data_q[MEM_W-1:VAL_W];
  assign rd_dist = rd_data_q[VAL_W-1:0];

  always_ff @(posedge clk_i) begin
    if (start_sum) begin
      acc_ir_q   <= '0;
      acc_dist_q <= '0;
    end else if (rd_vld_q) begin
      acc_ir_q   <= acc_ir_q + SUM_W'(rd_ir);
      acc_dist_q <= acc_dist_q + SUM_W'(rd_dist);
    end
  end

  // --------------------------------------------------------------------------
  // Dividers: both run in lockstep on the same count
  // --------------------------------------------------------------------------
  apma_div u_div_ir (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_ir_q),
    .divisor_i  (n_q),
    .stat_o     (ir_stat),
    .quotient_o (ir_quot)
  );

  apma_div u_div_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_dist_q),
    .divisor_i  (n_q),
    .stat_o     (dist_stat),
    .quotient_o (dist_quot)
  );

  // --------------------------------------------------------------------------
  // Output register: holds a result while the next reply streams in
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      ir_out_q   <= ir_quot;
      dist_out_q <= dist_quot;
      samp_q     <= 3'(n_q);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'd0, samp_q, dist_out_q, ir_out_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_div_idle_at_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (!ir_stat.busy && !dist_stat.busy))
    else $error("divider started while busy");

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ir_stat.done == dist_stat.done) && (ir_stat.busy == dist_stat.busy))
    else $error("dividers out of step");

  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> (rd_cnt_q <= n_q))
    else $error("read sweep ran past the filled entries");

  a_div_done_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ir_stat.done && (state_q == ST_DIV)) |=> (state_q == ST_PUSH))
    else $error("divider result not taken");

endmodule

`default_nettype wire

/* tb/tb_ascii_pair_moving_average_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ascii_pair_moving_average_unit
// Streams sensor reply text into the averaging unit and checks every average
// beat against an in-bench model of the parser and the ring window. A short
// directed set covers saturation, sign handling, dropped bytes and replies
// that give no pair. Random replies follow, mostly well formed, under three
// idle patterns on the two stream sides.
// ----------------------------------------------------------------------------

module tb_ascii_pair_moving_average_unit;
  import apma_pkg::*;

  localparam int CLK_HALF   = 2;
  localparam int RST_CYCLES = 11;
  localparam int ITEMS      = 1150;
  localparam int TAIL       = 64;
  localparam int STALL_MAX  = 4000;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last;
  } reply_beat_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] ir_avg;
    logic signed [VAL_W-1:0] dist_avg;
    logic [2:0]              used;
  } pair_avg_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  reply_beat_t pending_beats [$];
  pair_avg_t   avg_expected [$];
  int          total_beats;
  int          beats_taken;
  int          err_cnt;
  int          stall_cnt;

  // Model state: ring of stored pairs and the text parser
  logic signed [VAL_W-1:0] ir_ring   [WINDOW];
  logic signed [VAL_W-1:0] dist_ring [WINDOW];
  int   ring_wr;
  bit   ring_full;
  bit   in_second;
  sub_e num_pos;
  bit   seen_text;
  int   ir_acc;
  int   dist_acc;
  bit   neg;

  ascii_pair_moving_average_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Parser and window model
  // --------------------------------------------------------------------------
  task automatic add_digit(inout int v, input int d);
    if (neg) begin
      v = v * 10 - d;
      if (v < -32768) v = -32768;
    end else begin
      v = v * 10 + d;
      if (v > 32767) v = 32767;
    end
  endtask

  task automatic feed_number(input logic [7:0] c, inout int v);
    bit is_digit;
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    case (num_pos)
      SUB_SKIP: begin
        if (c == CHAR_SPACE) begin
          num_pos = SUB_SKIP;
        end else if (c == CHAR_PLUS) begin
          neg     = 1'b0;
          num_pos = SUB_DIGIT;
        end else if (c == CHAR_MINUS) begin
          neg     = 1'b1;
          num_pos = SUB_DIGIT;
        end else if (is_digit) begin
          neg = 1'b0;
          add_digit(v, int'(c - CHAR_ZERO));
          num_pos = SUB_DIGIT;
        end else begin
          num_pos = SUB_DONE;
        end
      end
      SUB_DIGIT: begin
        if (is_digit) add_digit(v, int'(c - CHAR_ZERO));
        else num_pos = SUB_DONE;
      end
      default: num_pos = SUB_DONE;
    endcase
  endtask

  task automatic clear_parse();
    in_second = 1'b0;
    num_pos   = SUB_SKIP;
    seen_text = 1'b0;
    ir_acc    = 0;
    dist_acc  = 0;
    neg       = 1'b0;
  endtask

  // Advance the model by one accepted beat; queue an average when a pair closes
  task automatic predict_beat(input logic [7:0] c, input logic is_last);
    int        n;
    int        ir_sum;
    int        dist_sum;
    pair_avg_t avg;
    if (c >= CHAR_FIRST_KEPT && c <= CHAR_LAST_KEPT) begin
      if (!in_second) begin
        if (c == CHAR_COMMA) begin
          in_second = 1'b1;
          num_pos   = SUB_SKIP;
          neg       = 1'b0;
        end else begin
          seen_text = 1'b1;
          feed_number(c, ir_acc);
        end
      end else begin
        feed_number(c, dist_acc);
      end
    end
    if (is_last) begin
      if (in_second && seen_text) begin
        ir_ring[ring_wr]   = ir_acc[VAL_W-1:0];
        dist_ring[ring_wr] = dist_acc[VAL_W-1:0];
        ring_wr++;
        if (ring_wr >= WINDOW) begin
          ring_wr   = 0;
          ring_full = 1'b1;
        end
        n        = ring_full ? WINDOW : ring_wr;
        ir_sum   = 0;
        dist_sum = 0;
        for (int i = 0; i < n; i++) begin
          ir_sum   += ir_ring[i];
          dist_sum += dist_ring[i];
        end
        // integer division truncates toward zero, as the block does
        avg.ir_avg   = VAL_W'(ir_sum / n);
        avg.dist_avg = VAL_W'(dist_sum / n);
        avg.used     = 3'(n);
        avg_expected.push_back(avg);
      end
      clear_parse();
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] c);
    reply_beat_t b;
    b.rx_byte = c;
    b.last    = 1'b0;
    pending_beats.push_back(b);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] unprintable();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 31));
    return 8'($urandom_range(127, 255));
  endfunction

  // Printable char, now and then preceded by a byte the block must drop
  task automatic push_char(input logic [7:0] c);
    if ($urandom_range(0, 19) == 0) push_byte(unprintable());
    push_byte(c);
  endtask

  task automatic close_reply();
    reply_beat_t b;
    b      = pending_beats.pop_back();
    b.last = 1'b1;
    pending_beats.push_back(b);
  endtask

  task automatic push_number();
    int sel;
    int ndig;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) push_char(CHAR_SPACE);
    end
    sel = $urandom_range(0, 3);
    if (sel == 0) push_char(CHAR_MINUS);
    else if (sel == 1) push_char(CHAR_PLUS);
    if (sel < 2 && $urandom_range(0, 15) == 0) push_char(CHAR_SPACE);
    sel = $urandom_range(0, 9);
    if (sel == 0) ndig = 0;
    else if (sel < 3) ndig = $urandom_range(5, 6);
    else ndig = $urandom_range(1, 4);
    repeat (ndig) push_char(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
    if ($urandom_range(0, 7) == 0) push_char(8'($urandom_range(CHAR_FIRST_KEPT, CHAR_LAST_KEPT)));
  endtask

  task automatic build_random_reply();
    int kind;
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      // noise over the full byte range
      repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
    end else if (kind == 2) begin
      push_number();                   // no separate comma; the stray char may be one
      if (pending_beats.size() == 0 || pending_beats[$].last) push_byte(CHAR_SPACE);
    end else if (kind == 3) begin
      push_char(CHAR_COMMA);           // comma first
      push_number();
    end else begin
      push_number();
      if (pending_beats.size() == 0 || pending_beats[$].last) push_char(CHAR_SPACE);
      push_char(CHAR_COMMA);
      push_number();
      if ($urandom_range(0, 7) == 0) push_byte(unprintable());
    end
    close_reply();
  endtask

  // --------------------------------------------------------------------------
  // Idle patterns: receiver-heavy, then sender-heavy, then none
  // --------------------------------------------------------------------------
  function automatic int send_idle_pct();
    if (beats_taken < total_beats / 3) return 25;
    if (beats_taken < (2 * total_beats) / 3) return 46;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (beats_taken < total_beats / 3) return 46;
    if (beats_taken < (2 * total_beats) / 3) return 25;
    return 0;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: update the model on each accepted beat, then load the next one
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    reply_beat_t nb;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
      s_tlast  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_beat(s_tdata, s_tlast);
        beats_taken <= beats_taken + 1;
      end
      // hold the beat while it waits for tready
      if (!s_tvalid || s_tready) begin
        if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          nb = pending_beats.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nb.rx_byte;
          s_tlast  <= nb.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each average beat with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    pair_avg_t want;
    int        errs;
    errs = 0;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (avg_expected.size() == 0) begin
          $error("average beat with none expected: tdata %h", m_tdata);
          errs++;
        end else begin
          want = avg_expected.pop_front();
          if (m_tdata[15:0] !== want.ir_avg) begin
            $error("ir_average: expected %0d, actual %0d",
                   want.ir_avg, $signed(m_tdata[15:0]));
            errs++;
          end
          if (m_tdata[31:16] !== want.dist_avg) begin
            $error("distance_average: expected %0d, actual %0d",
                   want.dist_avg, $signed(m_tdata[31:16]));
            errs++;
          end
          if (m_tdata[34:32] !== want.used) begin
            $error("samples_used: expected %0d, actual %0d", want.used, m_tdata[34:32]);
            errs++;
          end
          if (m_tdata[39:35] !== 5'd0) begin
            $error("tdata padding: expected 0, actual %h", m_tdata[39:35]);
            errs++;
          end
        end
      end
      if (errs != 0) err_cnt <= err_cnt + errs;
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct());
    end
  end

  // Watchdog: drop the run when no beat moves on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= STALL_MAX) begin
        $display("FAIL");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: build stimulus, reset, drain, report
  // --------------------------------------------------------------------------
  initial begin
    beats_taken = 0;
    err_cnt     = 0;
    stall_cnt   = 0;
    ring_wr     = 0;
    ring_full   = 1'b0;
    clear_parse();

    // Directed replies
    push_text(",5");           close_reply();   // comma first: no pair
    push_text("7");            close_reply();   // no comma: no pair
    push_text("99999,-99999"); close_reply();   // saturate both ways
    push_text("- 3,+");        close_reply();   // space after sign, bare sign
    push_text("1");
    push_byte(8'hFF);
    push_text(",2");
    push_byte(8'h0A);          close_reply();   // dropped bytes, last on an unprintable
    push_text("~,3");
    push_byte(8'h7F);
    push_text(",4");           close_reply();   // non-numeric first, later comma

    while (pending_beats.size() < ITEMS) build_random_reply();
    total_beats = pending_beats.size();

    repeat (RST_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // wait for the queue to empty and every expected average to arrive
    do begin
      @(negedge clk_i);
    end while (pending_beats.size() > 0 || s_tvalid || avg_expected.size() > 0);
    repeat (TAIL) @(negedge clk_i);

    if (err_cnt == 0 && avg_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
